/* hdl/csr_spmv_pkg.sv */
// Shared types, codes and widths for the compressed-row sparse matrix-vector unit.
package csr_spmv_pkg;

   localparam int IDX_W       = 10;
   localparam int DATA_W      = 32;
   localparam int ACC_W       = 64;
   localparam int ACTION_W    = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_ENTRY_W = DATA_W + IDX_W;
   localparam int OUT_DEPTH   = 8;
   localparam int OUT_PTR_W   = 3;
   localparam int OUT_CNT_W   = 4;

   typedef logic [ACTION_W-1:0]  action_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam action_type ACTION_LOAD    = 2'd0;
   localparam action_type ACTION_NONZERO = 2'd1;
   localparam action_type ACTION_CLOSE   = 2'd2;

   localparam csr_index_type CSR_ALPHA = 2'd0;
   localparam csr_index_type CSR_BETA  = 2'd1;

   localparam logic signed [DATA_W-1:0] ALPHA_RESET = 32'sd65536;
   localparam logic signed [DATA_W-1:0] BETA_RESET  = 32'sd0;

endpackage

/* hdl/csr_spmv_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module csr_spmv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/csr_sparse_matrix_vector_multiply_unit.sv */
// Top level of the compressed-row sparse matrix-vector unit: y = alpha*A*x + beta*y.
//
//  channel | direction | tdata / data fields (low bit up)                     | sideband
//  req_    | in        | index[9:0] value[41:10] prior_output[73:42] zero pad | tuser: action
//  rsp_    | out       | result_value[31:0] row_number[41:32] zero pad        | none
//  csr_    | in        | csr_index: register, csr_data: 32-bit value          | none
//
//  One request transaction is taken every cycle while req_tready is high; the
//  vector read, the multiply and the accumulate each sit in their own pipeline
//  stage, and the close math spans the scale, clamp and final-add stages.
//  Results wait in an eight-entry output queue; req_tready drops only while
//  eight row closes are in flight or queued, so a stalled rsp_ side only
//  blocks the request side once that queue is committed.
//  Reset is synchronous and active high; the vector store is not cleared.
module csr_sparse_matrix_vector_multiply_unit #(
   parameter int VECTOR_LENGTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // index[9:0], value[41:10], prior_output[73:42]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // result_value[31:0], row_number[41:32]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int STORE_DEPTH = (VECTOR_LENGTH < 1024) ? VECTOR_LENGTH : 1024;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int IDX_W  = csr_spmv_pkg::IDX_W;
   localparam int DATA_W = csr_spmv_pkg::DATA_W;
   localparam int ACC_W  = csr_spmv_pkg::ACC_W;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [63:0]      A_LIM   = 64'sd17179869184;

   // ---------------------------------------------------------------- request unpack
   logic [IDX_W-1:0]         req_index;
   logic signed [DATA_W-1:0] req_value;
   logic signed [DATA_W-1:0] req_prior;
   csr_spmv_pkg::action_type req_action;
   logic                     req_fire;
   logic                     req_in_range;

   assign req_index    = req_tdata[9:0];
   assign req_value    = $signed(req_tdata[41:10]);
   assign req_prior    = $signed(req_tdata[73:42]);
   assign req_action   = req_tuser;
   assign req_fire     = req_tvalid && req_tready;
   assign req_in_range = 32'(req_index) < STORE_DEPTH;

   // ---------------------------------------------------------------- configuration
   logic signed [DATA_W-1:0] alpha_ff;
   logic signed [DATA_W-1:0] beta_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= csr_spmv_pkg::ALPHA_RESET;
         beta_ff  <= csr_spmv_pkg::BETA_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == csr_spmv_pkg::CSR_ALPHA) begin
            alpha_ff <= $signed(csr_data);
         end else if (csr_index == csr_spmv_pkg::CSR_BETA) begin
            beta_ff <= $signed(csr_data);
         end
      end
   end

   // ---------------------------------------------------------------- vector store
   logic [DATA_W-1:0] ram_rd_data;

   csr_spmv_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_vector_store (
      .clock   (clock),
      .wr_en   (req_fire && req_action == csr_spmv_pkg::ACTION_LOAD && req_in_range),
      .wr_addr (req_index[ADDR_W-1:0]),
      .wr_data (req_value),
      .rd_en   (req_fire && req_action == csr_spmv_pkg::ACTION_NONZERO),
      .rd_addr (req_index[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------- stage 1: multiply
   logic                     s1_valid_ff;
   csr_spmv_pkg::action_type s1_action_ff;
   logic                     s1_in_range_ff;
   logic signed [DATA_W-1:0] s1_value_ff;
   logic signed [DATA_W-1:0] s1_prior_ff;
   logic signed [DATA_W-1:0] s1_x;
   logic signed [ACC_W-1:0]  s1_product;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
      end
      s1_action_ff   <= req_action;
      s1_in_range_ff <= req_in_range;
      s1_value_ff    <= req_value;
      s1_prior_ff    <= req_prior;
   end

   // A column past the end of the store reads as zero.
   assign s1_x       = s1_in_range_ff ? $signed(ram_rd_data) : '0;
   assign s1_product = s1_value_ff * s1_x;

   // ---------------------------------------------------------------- stage 2: accumulate
   logic                     s2_valid_ff;
   csr_spmv_pkg::action_type s2_action_ff;
   logic signed [ACC_W-1:0]  s2_product_ff;
   logic signed [DATA_W-1:0] s2_prior_ff;
   logic signed [ACC_W-1:0]  s2_addend;
   logic [ACC_W:0]           s2_sum;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic [IDX_W-1:0]         row_ff;
   logic [IDX_W-1:0]         row_in;
   logic                     s2_close;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_action_ff  <= s1_action_ff;
      s2_product_ff <= s1_product;
      s2_prior_ff   <= s1_prior_ff;
   end

   assign s2_addend = s2_product_ff >>> 16;
   assign s2_sum    = {acc_ff[ACC_W-1], acc_ff} + {s2_addend[ACC_W-1], s2_addend};
   assign s2_close  = s2_valid_ff && s2_action_ff == csr_spmv_pkg::ACTION_CLOSE;

   always_comb begin
      acc_in = acc_ff;
      row_in = row_ff;
      if (s2_valid_ff && s2_action_ff == csr_spmv_pkg::ACTION_NONZERO) begin
         // The accumulator saturates when the two top bits of the sum disagree.
         if (s2_sum[ACC_W] != s2_sum[ACC_W-1]) begin
            acc_in = s2_sum[ACC_W] ? ACC_MIN : ACC_MAX;
         end else begin
            acc_in = $signed(s2_sum[ACC_W-1:0]);
         end
      end else if (s2_close) begin
         acc_in = '0;
         row_in = row_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         row_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------- stage 3: scale
   logic                     s3_valid_ff;
   logic signed [ACC_W-1:0]  s3_sum_ff;
   logic signed [DATA_W-1:0] s3_prior_ff;
   logic [IDX_W-1:0]         s3_row_ff;
   logic signed [63:0]       s3_a;
   logic signed [63:0]       s3_b;
   logic signed [63:0]       s3_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_close;
      end
      s3_sum_ff   <= acc_ff;
      s3_prior_ff <= s2_prior_ff;
      s3_row_ff   <= row_ff;
   end

   // The sum is split so that each product stays within 32 by 33 bits.
   assign s3_a = alpha_ff * $signed(s3_sum_ff[63:32]);
   assign s3_b = alpha_ff * $signed({1'b0, s3_sum_ff[31:0]});
   assign s3_c = beta_ff * s3_prior_ff;

   // ---------------------------------------------------------------- stage 4: clamp, low sum
   logic                 s4_valid_ff;
   logic signed [63:0]   s4_a_ff;
   logic signed [63:0]   s4_b_ff;
   logic signed [63:0]   s4_c_ff;
   logic [IDX_W-1:0]     s4_row_ff;
   logic signed [35:0]   s4_a_clamp;
   logic [17:0]          s4_frac;
   logic signed [49:0]   s4_bc;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_a_ff   <= s3_a;
      s4_b_ff   <= s3_b;
      s4_c_ff   <= s3_c;
      s4_row_ff <= s3_row_ff;
   end

   always_comb begin
      if (s4_a_ff > A_LIM) begin
         s4_a_clamp = 36'sh400000000;
      end else if (s4_a_ff < -A_LIM) begin
         s4_a_clamp = -36'sh400000000;
      end else begin
         s4_a_clamp = $signed(s4_a_ff[35:0]);
      end
   end

   // Fractions of both terms plus one half decide the rounding carry.
   assign s4_frac = {2'b00, s4_b_ff[15:0]} + {2'b00, s4_c_ff[15:0]} + 18'h08000;
   assign s4_bc   = {{2{s4_b_ff[63]}}, s4_b_ff[63:16]}
                  + {{2{s4_c_ff[63]}}, s4_c_ff[63:16]}
                  + {48'd0, s4_frac[17:16]};

   // ---------------------------------------------------------------- stage 5: final add
   logic                 s5_valid_ff;
   logic signed [35:0]   s5_a_ff;
   logic signed [49:0]   s5_bc_ff;
   logic [IDX_W-1:0]     s5_row_ff;
   logic signed [52:0]   s5_q;
   logic [DATA_W-1:0]    s5_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      s5_a_ff   <= s4_a_clamp;
      s5_bc_ff  <= s4_bc;
      s5_row_ff <= s4_row_ff;
   end

   assign s5_q = {s5_a_ff[35], s5_a_ff, 16'd0} + {{3{s5_bc_ff[49]}}, s5_bc_ff};

   always_comb begin
      if (s5_q[52:31] != {22{s5_q[52]}}) begin
         s5_result = s5_q[52] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         s5_result = s5_q[31:0];
      end
   end

   // ---------------------------------------------------------------- output queue
   localparam int OUT_DEPTH = csr_spmv_pkg::OUT_DEPTH;
   localparam int PTR_W     = csr_spmv_pkg::OUT_PTR_W;
   localparam int CNT_W     = csr_spmv_pkg::OUT_CNT_W;
   localparam int ENTRY_W   = csr_spmv_pkg::RSP_ENTRY_W;

   logic [ENTRY_W-1:0] queue_ff [OUT_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   pending_ff;
   logic [CNT_W-1:0]   pending_in;
   logic               rsp_fire;
   logic               close_taken;

   assign rsp_fire    = rsp_tvalid && rsp_tready;
   assign close_taken = req_fire && req_action == csr_spmv_pkg::ACTION_CLOSE;

   // Row closes accepted but not yet delivered; this bounds the queue occupancy.
   always_comb begin
      pending_in = pending_ff;
      if (close_taken && !rsp_fire) begin
         pending_in = pending_ff + 1'b1;
      end else if (!close_taken && rsp_fire) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_valid_ff) begin
         queue_ff[wr_ptr_ff] <= {s5_row_ff, s5_result};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
         if (s5_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (s5_valid_ff && !rsp_fire) begin
            count_ff <= count_ff + 1'b1;
         end else if (!s5_valid_ff && rsp_fire) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign req_tready = pending_ff < CNT_W'(OUT_DEPTH);
   assign rsp_tvalid = count_ff != '0;
   assign rsp_tdata  = {{(csr_spmv_pkg::RSP_TDATA_W - ENTRY_W){1'b0}}, queue_ff[rd_ptr_ff]};

endmodule

/* hdl/csr_spmv_checker.sv */
// Port-level checker for the sparse matrix-vector unit, bound to the top level.
module csr_spmv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   logic [9:0]  expect_row_ff;
   logic [15:0] open_ff;
   logic        close_in;
   logic        rsp_fire;

   assign close_in = req_tvalid && req_tready && req_tuser == csr_spmv_pkg::ACTION_CLOSE;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_row_ff <= '0;
         open_ff       <= '0;
      end else begin
         if (rsp_fire) begin
            expect_row_ff <= expect_row_ff + 1'b1;
         end
         if (close_in && !rsp_fire) begin
            open_ff <= open_ff + 1'b1;
         end else if (!close_in && rsp_fire) begin
            open_ff <= open_ff - 1'b1;
         end
      end
   end

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result transaction offered right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result transaction changed or dropped");

   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[41:32] == expect_row_ff)
      else $error("row number out of sequence");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> open_ff != '0)
      else $error("result transaction without an open row close");

endmodule

bind csr_sparse_matrix_vector_multiply_unit csr_spmv_checker u_checker (.*);
